@@ rtl/mlfq_pkg.sv @@
// Shared codes and types for the three-level feedback queue scheduler.
package mlfq_pkg;

   // Request function codes.
   localparam logic FUNC_ADMIT    = 1'b0;
   localparam logic FUNC_DISPATCH = 1'b1;

   // Response status codes.
   localparam logic [2:0] STATUS_ADMITTED = 3'd0;
   localparam logic [2:0] STATUS_REJECTED = 3'd1;
   localparam logic [2:0] STATUS_REQUEUED = 3'd2;
   localparam logic [2:0] STATUS_FINISHED = 3'd3;
   localparam logic [2:0] STATUS_IDLE     = 3'd4;

   // Queue levels.
   localparam logic [1:0] LEVEL_HIGH = 2'd0;
   localparam logic [1:0] LEVEL_MID  = 2'd1;
   localparam logic [1:0] LEVEL_LOW  = 2'd2;
   localparam int         LEVELS     = 3;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_QUANTUM_HIGH = 2'd0;
   localparam logic [1:0] CSR_QUANTUM_MID  = 2'd1;
   localparam logic [1:0] CSR_QUANTUM_LOW  = 2'd2;

   // Quantum reset values.
   localparam logic [15:0] QUANTUM_HIGH_RESET = 16'd2;
   localparam logic [15:0] QUANTUM_MID_RESET  = 16'd4;
   localparam logic [15:0] QUANTUM_LOW_RESET  = 16'd8;

   // Pointer update command issued by the control logic once per item.
   typedef struct packed {
      logic       pop;
      logic [1:0] pop_level;
      logic       push;
      logic [1:0] push_level;
   } ptr_cmd_type;

endpackage

@@ rtl/mlfq_entry_ram.sv @@
// Single-port-write, single-port-read queue entry memory with registered read data.
module mlfq_entry_ram #(
   parameter int WIDTH     = 40,
   parameter int ADDR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [2**ADDR_BITS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read so a stalled item keeps its entry.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mlfq_queue_ptrs.sv @@
// Head pointers and fill counts of the three circular queues.
module mlfq_queue_ptrs #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mlfq_pkg::ptr_cmd_type          cmd,
   input  logic [1:0]                     rd_level,
   output logic [$clog2(QUEUE_DEPTH)-1:0] head_idx,
   output logic [$clog2(QUEUE_DEPTH)-1:0] tail_idx,
   output logic [2:0]                     nonempty
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = IW + 2;

   logic [IW-1:0] head_ff [mlfq_pkg::LEVELS];
   logic [IW-1:0] head_in [mlfq_pkg::LEVELS];
   logic [CW-1:0] fill_ff [mlfq_pkg::LEVELS];
   logic [CW-1:0] fill_in [mlfq_pkg::LEVELS];

   logic [IW-1:0] push_head;
   logic [CW-1:0] push_fill;
   logic [SW-1:0] tail_sum;

   always_comb begin
      unique case (rd_level)
         mlfq_pkg::LEVEL_HIGH: head_idx = head_ff[0];
         mlfq_pkg::LEVEL_MID:  head_idx = head_ff[1];
         default:              head_idx = head_ff[2];
      endcase
      unique case (cmd.push_level)
         mlfq_pkg::LEVEL_HIGH: begin
            push_head = head_ff[0];
            push_fill = fill_ff[0];
         end
         mlfq_pkg::LEVEL_MID: begin
            push_head = head_ff[1];
            push_fill = fill_ff[1];
         end
         default: begin
            push_head = head_ff[2];
            push_fill = fill_ff[2];
         end
      endcase
   end

   // The tail is taken from the values before this item's pop; when the pop and
   // the push hit the same level, head+1 plus fill-1 lands on the same slot.
   always_comb begin
      tail_sum = SW'(push_head) + SW'(push_fill);
      if (tail_sum >= SW'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SW'(QUEUE_DEPTH);
      end
      tail_idx = tail_sum[IW-1:0];
   end

   always_comb begin
      logic inc;
      logic dec;
      for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
         inc        = cmd.push && (cmd.push_level == 2'(i));
         dec        = cmd.pop && (cmd.pop_level == 2'(i));
         head_in[i] = head_ff[i];
         fill_in[i] = fill_ff[i];
         if (dec) begin
            head_in[i] = (head_ff[i] == IW'(QUEUE_DEPTH - 1)) ? '0 : head_ff[i] + 1'b1;
         end
         if (inc && !dec) begin
            fill_in[i] = fill_ff[i] + 1'b1;
         end else if (dec && !inc) begin
            fill_in[i] = fill_ff[i] - 1'b1;
         end
         nonempty[i] = (fill_ff[i] != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < mlfq_pkg::LEVELS; i++) begin
            head_ff[i] <= head_in[i];
            fill_ff[i] <= fill_in[i];
         end
      end
   end

endmodule

@@ rtl/mlfq_three_level_scheduler_unit.sv @@
// Top level of the three-level feedback queue scheduler.
// A request is taken only in idle; when a dispatch is accepted, the head of
// the first non-empty queue is read from the shared entry memory. In the
// execute state the entry comes back, the slice is computed, a demoted or
// admitted entry is written to its queue tail and the result is loaded into
// the response register. The execute step waits while an earlier response is
// still held by rsp_stall. The single entry memory has one read and one write
// port; no new request is taken until the execute step is done. No clearing
// pass follows reset: only entries below a fill count are read.
module mlfq_three_level_scheduler_unit #(
   parameter int QUEUE_DEPTH = 64,
   parameter int ID_BITS     = 8,
   parameter int TIME_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_proc_id,
   input  logic [15:0] req_duration,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_served_id,
   output logic [1:0]  rsp_level,
   output logic [15:0] rsp_slice_time,
   output logic [31:0] rsp_finish_time,
   output logic [31:0] rsp_wait_time,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = IW + 2;
   localparam int EW = ID_BITS + 2 * TIME_BITS;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;

   logic [15:0] quantum_high_ff, quantum_mid_ff, quantum_low_ff;
   logic [CW-1:0] live_ff, live_in;
   logic [31:0] elapsed_ff, elapsed_in;

   logic                 func_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [TIME_BITS-1:0] dur_ff;
   logic [1:0]           level_ff;
   logic                 found_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_id_ff, rsp_id_in;
   logic [1:0]  rsp_level_ff, rsp_level_in;
   logic [15:0] rsp_slice_ff, rsp_slice_in;
   logic [31:0] rsp_finish_ff, rsp_finish_in;
   logic [31:0] rsp_wait_ff, rsp_wait_in;

   mlfq_pkg::ptr_cmd_type cmd;
   logic [IW-1:0] head_idx, tail_idx;
   logic [2:0]    nonempty;
   logic [1:0]    pick_level;
   logic          pick_found;

   logic          mem_wr_en, mem_rd_en;
   logic [EW-1:0] mem_wr_data, mem_rd_data;

   logic                 accept, fire, out_free;
   logic [31:0]          id_wide, dur_wide;
   logic [ID_BITS-1:0]   ent_id;
   logic [TIME_BITS-1:0] ent_dur, ent_rem;
   logic [31:0]          rem32, quantum32, sid32, sum32;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = (state_ff == ST_EXEC) && out_free;

   assign id_wide  = 32'(req_proc_id);
   assign dur_wide = 32'(req_duration);

   always_comb begin
      pick_found = |nonempty;
      if (nonempty[0]) begin
         pick_level = mlfq_pkg::LEVEL_HIGH;
      end else if (nonempty[1]) begin
         pick_level = mlfq_pkg::LEVEL_MID;
      end else begin
         pick_level = mlfq_pkg::LEVEL_LOW;
      end
   end

   assign mem_rd_en = accept && (req_func == mlfq_pkg::FUNC_DISPATCH) && pick_found;

   mlfq_queue_ptrs #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_ptrs (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_level (pick_level),
      .head_idx (head_idx),
      .tail_idx (tail_idx),
      .nonempty (nonempty)
   );

   mlfq_entry_ram #(
      .WIDTH    (EW),
      .ADDR_BITS(AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr({cmd.push_level, tail_idx}),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr({pick_level, head_idx}),
      .rd_data(mem_rd_data)
   );

   assign ent_id  = mem_rd_data[EW-1 -: ID_BITS];
   assign ent_dur = mem_rd_data[2*TIME_BITS-1 -: TIME_BITS];
   assign ent_rem = mem_rd_data[TIME_BITS-1:0];
   assign rem32   = 32'(ent_rem);

   always_comb begin
      unique case (level_ff)
         mlfq_pkg::LEVEL_HIGH: quantum32 = 32'(quantum_high_ff);
         mlfq_pkg::LEVEL_MID:  quantum32 = 32'(quantum_mid_ff);
         default:              quantum32 = 32'(quantum_low_ff);
      endcase
   end

   // Execute step: pointer command, memory write-back and response for one item.
   always_comb begin
      cmd           = '0;
      mem_wr_en     = 1'b0;
      mem_wr_data   = {id_ff, dur_ff, dur_ff};
      live_in       = live_ff;
      elapsed_in    = elapsed_ff;
      sid32         = 32'(id_ff);
      sum32         = elapsed_ff + rem32;
      rsp_status_in = mlfq_pkg::STATUS_IDLE;
      rsp_level_in  = mlfq_pkg::LEVEL_HIGH;
      rsp_slice_in  = '0;
      rsp_finish_in = '0;
      rsp_wait_in   = '0;

      if (func_ff == mlfq_pkg::FUNC_ADMIT) begin
         if (live_ff >= CW'(QUEUE_DEPTH)) begin
            rsp_status_in = mlfq_pkg::STATUS_REJECTED;
         end else begin
            rsp_status_in  = mlfq_pkg::STATUS_ADMITTED;
            cmd.push       = 1'b1;
            cmd.push_level = mlfq_pkg::LEVEL_HIGH;
            mem_wr_en      = 1'b1;
            live_in        = live_ff + 1'b1;
         end
      end else if (!found_ff) begin
         sid32 = '0;
      end else begin
         sid32         = 32'(ent_id);
         rsp_level_in  = level_ff;
         cmd.pop       = 1'b1;
         cmd.pop_level = level_ff;
         if (rem32 <= quantum32) begin
            rsp_status_in = mlfq_pkg::STATUS_FINISHED;
            rsp_slice_in  = rem32[15:0];
            elapsed_in    = sum32;
            rsp_finish_in = sum32;
            rsp_wait_in   = sum32 - 32'(ent_dur);
            if (live_ff != '0) begin
               live_in = live_ff - 1'b1;
            end
         end else begin
            rsp_status_in  = mlfq_pkg::STATUS_REQUEUED;
            rsp_slice_in   = quantum32[15:0];
            elapsed_in     = elapsed_ff + quantum32;
            cmd.push       = 1'b1;
            cmd.push_level = (level_ff == mlfq_pkg::LEVEL_HIGH) ? mlfq_pkg::LEVEL_MID
                                                                 : mlfq_pkg::LEVEL_LOW;
            mem_wr_en      = 1'b1;
            mem_wr_data    = {ent_id, ent_dur, TIME_BITS'(rem32 - quantum32)};
         end
      end
      rsp_id_in = sid32[7:0];

      if (!fire) begin
         cmd       = '0;
         mem_wr_en = 1'b0;
         live_in   = live_ff;
         elapsed_in = elapsed_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         live_ff         <= '0;
         elapsed_ff      <= '0;
         quantum_high_ff <= mlfq_pkg::QUANTUM_HIGH_RESET;
         quantum_mid_ff  <= mlfq_pkg::QUANTUM_MID_RESET;
         quantum_low_ff  <= mlfq_pkg::QUANTUM_LOW_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         live_ff      <= live_in;
         elapsed_ff   <= elapsed_in;
         if (csr_write) begin
            unique case (csr_index)
               mlfq_pkg::CSR_QUANTUM_HIGH: quantum_high_ff <= csr_wdata;
               mlfq_pkg::CSR_QUANTUM_MID:  quantum_mid_ff  <= csr_wdata;
               mlfq_pkg::CSR_QUANTUM_LOW:  quantum_low_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         id_ff    <= id_wide[ID_BITS-1:0];
         dur_ff   <= dur_wide[TIME_BITS-1:0];
         level_ff <= pick_level;
         found_ff <= pick_found;
      end
      if (fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_slice_ff  <= rsp_slice_in;
         rsp_finish_ff <= rsp_finish_in;
         rsp_wait_ff   <= rsp_wait_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_served_id   = rsp_id_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_slice_time  = rsp_slice_ff;
   assign rsp_finish_time = rsp_finish_ff;
   assign rsp_wait_time   = rsp_wait_ff;

endmodule

@@ rtl/mlfq_checker.sv @@
// Port-level checks of the scheduler and the bind that attaches them.
module mlfq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_served_id,
   input logic [1:0]  rsp_level,
   input logic [15:0] rsp_slice_time,
   input logic [31:0] rsp_finish_time,
   input logic [31:0] rsp_wait_time
);

   // A held response beat keeps its status, served id and finish time.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_served_id)
                                 && $stable(rsp_finish_time))
      else $error("response payload changed while stalled");

   // Each accepted request holds req_stall high while it executes.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted back to back");

   // An idle dispatch reports nothing but its status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == mlfq_pkg::STATUS_IDLE
         |-> rsp_served_id == 8'd0 && rsp_level == mlfq_pkg::LEVEL_HIGH
         && rsp_slice_time == 16'd0 && rsp_finish_time == 32'd0 && rsp_wait_time == 32'd0)
      else $error("idle response carries data");

   // Only a finished process carries finish and wait times.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mlfq_pkg::STATUS_FINISHED
         |-> rsp_finish_time == 32'd0 && rsp_wait_time == 32'd0)
      else $error("times reported for an unfinished process");

   // Admission results sit at the high level with no slice.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == mlfq_pkg::STATUS_ADMITTED ||
                    rsp_status == mlfq_pkg::STATUS_REJECTED)
         |-> rsp_level == mlfq_pkg::LEVEL_HIGH && rsp_slice_time == 16'd0)
      else $error("admission response with level or slice");

endmodule

bind mlfq_three_level_scheduler_unit mlfq_checker u_mlfq_checker (.*);
